// ===== hdl/bilinear_image_resize_unit_assert.svh =====
// Assertion macros used by the scaler RTL.
`ifndef BILINEAR_IMAGE_RESIZE_UNIT_ASSERT_SVH
`define BILINEAR_IMAGE_RESIZE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on aclk, quiet during reset.
`define BIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, quiet during reset.
`define BIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bir_pkg.sv =====
`timescale 1ns / 1ps
package bir_pkg;

    localparam int DEF_MAX_SOURCE_ROWS = 512;
    localparam int DEF_MAX_SOURCE_COLS = 512;
    localparam int DEF_WEIGHT_BITS     = 8;

    localparam int FRAC_BITS = 16;
    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int COORD_W   = 12;
    localparam int SCALE_W   = 24;
    localparam int SRC_W     = 10;
    localparam int OUT_W     = 13;
    localparam int IP_W      = COORD_W + SCALE_W - FRAC_BITS;

    typedef enum logic [2:0] {
        REG_SOURCE_ROWS  = 3'd0,
        REG_SOURCE_COLS  = 3'd1,
        REG_INV_ROW_SCL  = 3'd2,
        REG_INV_COL_SCL  = 3'd3,
        REG_OUTPUT_ROWS  = 3'd4,
        REG_OUTPUT_COLS  = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_INTERP = 1'b1
    } op_t;

endpackage

// ===== hdl/bilinear_image_resize_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Bits  Contents (lowest bit first)
// s_axis    in   48+1  tdata: row, col, blue, green, red; tuser: opcode
// m_axis    out  24+1  tdata: blue, green, red; tuser: range_error
// cfg       in   1+3+24  cfg_we, cfg_index, cfg_wdata
//
// One transfer in per cycle while m_axis is not stalled; every interpolate leaves on m_axis.
// Depth is set by the six register stages: input, scale multiply, edge
// mapping, bank read plus weight products, channel products, blend sum.
// Reset (aresetn, synchronous) clears valid bits and loads register defaults;
// the frame store is not cleared.
// A stall on m_axis holds every stage in place; s_tready follows it.
module bilinear_image_resize_unit #(
    parameter int MAX_SOURCE_ROWS = bir_pkg::DEF_MAX_SOURCE_ROWS,
    parameter int MAX_SOURCE_COLS = bir_pkg::DEF_MAX_SOURCE_COLS,
    parameter int WEIGHT_BITS     = bir_pkg::DEF_WEIGHT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row[11:0], col[23:12], blue, green, red
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // blue[7:0], green[15:8], red[23:16]
    output logic        m_tuser,   // range_error
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

`include "bilinear_image_resize_unit_assert.svh"

    localparam int RW   = $clog2(MAX_SOURCE_ROWS);
    localparam int CW   = $clog2(MAX_SOURCE_COLS);
    localparam int SRW  = $clog2(MAX_SOURCE_ROWS + 1);
    localparam int SCW  = $clog2(MAX_SOURCE_COLS + 1);
    localparam int HRW  = (RW > 1) ? RW - 1 : 1;
    localparam int HCW  = (CW > 1) ? CW - 1 : 1;
    localparam int WB   = WEIGHT_BITS;
    localparam int AW   = 2 * WB + 2;
    localparam int PW   = bir_pkg::CH_W + AW;
    localparam int SW   = PW + 2;
    localparam int POSW = bir_pkg::COORD_W + bir_pkg::SCALE_W;
    localparam int IPW  = bir_pkg::IP_W;
    localparam logic [WB:0] W_FULL = (WB + 1)'(1) << WB;

    // ---------------- configuration registers ----------------
    logic [bir_pkg::SRC_W-1:0]   src_rows_reg, src_cols_reg;
    logic [bir_pkg::SCALE_W-1:0] irs_reg, ics_reg;
    logic [bir_pkg::OUT_W-1:0]   out_rows_reg, out_cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_rows_reg <= bir_pkg::SRC_W'(512);
            src_cols_reg <= bir_pkg::SRC_W'(512);
            irs_reg      <= bir_pkg::SCALE_W'(65536);
            ics_reg      <= bir_pkg::SCALE_W'(65536);
            out_rows_reg <= bir_pkg::OUT_W'(512);
            out_cols_reg <= bir_pkg::OUT_W'(512);
        end else if (cfg_we) begin
            unique case (cfg_index)
                bir_pkg::REG_SOURCE_ROWS: src_rows_reg <= cfg_wdata[bir_pkg::SRC_W-1:0];
                bir_pkg::REG_SOURCE_COLS: src_cols_reg <= cfg_wdata[bir_pkg::SRC_W-1:0];
                bir_pkg::REG_INV_ROW_SCL: irs_reg      <= cfg_wdata;
                bir_pkg::REG_INV_COL_SCL: ics_reg      <= cfg_wdata;
                bir_pkg::REG_OUTPUT_ROWS: out_rows_reg <= cfg_wdata[bir_pkg::OUT_W-1:0];
                bir_pkg::REG_OUTPUT_COLS: out_cols_reg <= cfg_wdata[bir_pkg::OUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective source size: zero reads as one, oversize saturates to the store.
    logic [SRW-1:0] rows_eff;
    logic [SCW-1:0] cols_eff;
    logic [12:0]    rows_w, cols_w;

    always_comb begin
        rows_w = {3'b0, src_rows_reg};
        cols_w = {3'b0, src_cols_reg};
        if (rows_w == 13'd0)                     rows_eff = SRW'(1);
        else if (rows_w > 13'(MAX_SOURCE_ROWS))  rows_eff = SRW'(MAX_SOURCE_ROWS);
        else                                     rows_eff = SRW'(rows_w);
        if (cols_w == 13'd0)                     cols_eff = SCW'(1);
        else if (cols_w > 13'(MAX_SOURCE_COLS))  cols_eff = SCW'(MAX_SOURCE_COLS);
        else                                     cols_eff = SCW'(cols_w);
    end

    // Whole pipe advances together; the output register frees the input side.
    logic adv;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: input register ----------------
    logic        s1_v_reg;
    logic        s1_op_reg;
    logic [11:0] s1_row_reg, s1_col_reg;
    logic [23:0] s1_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s1_v_reg <= 1'b0;
        else if (adv) s1_v_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg  <= s_tuser;
            s1_row_reg <= s_tdata[11:0];
            s1_col_reg <= s_tdata[23:12];
            s1_pix_reg <= s_tdata[47:24];
        end
    end

    // ---------------- stage 2: scale multiply, range check ----------------
    logic            s2_v_reg, s2_op_reg, s2_rerr_reg, s2_ldok_reg;
    logic [POSW-1:0] s2_posr_reg, s2_posc_reg;
    logic [RW-1:0]   s2_lrow_reg;
    logic [CW-1:0]   s2_lcol_reg;
    logic [23:0]     s2_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s2_v_reg <= 1'b0;
        else if (adv) s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_op_reg   <= s1_op_reg;
            s2_posr_reg <= POSW'(s1_row_reg) * POSW'(irs_reg);
            s2_posc_reg <= POSW'(s1_col_reg) * POSW'(ics_reg);
            s2_rerr_reg <= ({1'b0, s1_row_reg} >= out_rows_reg) ||
                           ({1'b0, s1_col_reg} >= out_cols_reg);
            // drop loads that fall outside the store
            s2_ldok_reg <= (13'(s1_row_reg) < 13'(MAX_SOURCE_ROWS)) &&
                           (13'(s1_col_reg) < 13'(MAX_SOURCE_COLS));
            s2_lrow_reg <= s1_row_reg[RW-1:0];
            s2_lcol_reg <= s1_col_reg[CW-1:0];
            s2_pix_reg  <= s1_pix_reg;
        end
    end

    // ---------------- stage 3: edge mapping ----------------
    logic [IPW-1:0] ipr, ipc;
    logic [SRW-1:0] rlast;
    logic [SCW-1:0] clast;
    logic [RW-1:0]  r0, r1;
    logic [CW-1:0]  c0, c1;
    logic [WB-1:0]  wr, wc;

    always_comb begin
        ipr   = s2_posr_reg[POSW-1:bir_pkg::FRAC_BITS];
        ipc   = s2_posc_reg[POSW-1:bir_pkg::FRAC_BITS];
        rlast = rows_eff - SRW'(1);
        clast = cols_eff - SCW'(1);
        wr    = s2_posr_reg[bir_pkg::FRAC_BITS-WB +: WB];
        wc    = s2_posc_reg[bir_pkg::FRAC_BITS-WB +: WB];
        // past the last row or column: saturate and drop the weight
        if (ipr > IPW'(rlast)) begin
            r0 = RW'(rlast);
            wr = '0;
        end else begin
            r0 = RW'(ipr);
        end
        if (ipc > IPW'(clast)) begin
            c0 = CW'(clast);
            wc = '0;
        end else begin
            c0 = CW'(ipc);
        end
        // next neighbour past the edge: step back, or stay at zero
        if (SRW'(r0) == rlast) r1 = (r0 != '0) ? r0 - RW'(1) : '0;
        else                   r1 = r0 + RW'(1);
        if (SCW'(c0) == clast) c1 = (c0 != '0) ? c0 - CW'(1) : '0;
        else                   c1 = c0 + CW'(1);
    end

    logic          s3_v_reg, s3_op_reg, s3_rerr_reg, s3_ldok_reg;
    logic [RW-1:0] s3_r0_reg, s3_r1_reg, s3_lrow_reg;
    logic [CW-1:0] s3_c0_reg, s3_c1_reg, s3_lcol_reg;
    logic [WB-1:0] s3_wr_reg, s3_wc_reg;
    logic [23:0]   s3_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s3_v_reg <= 1'b0;
        else if (adv) s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_op_reg   <= s2_op_reg;
            s3_rerr_reg <= s2_rerr_reg;
            s3_ldok_reg <= s2_ldok_reg;
            s3_r0_reg   <= r0;
            s3_r1_reg   <= r1;
            s3_c0_reg   <= c0;
            s3_c1_reg   <= c1;
            s3_wr_reg   <= wr;
            s3_wc_reg   <= wc;
            s3_lrow_reg <= s2_lrow_reg;
            s3_lcol_reg <= s2_lcol_reg;
            s3_pix_reg  <= s2_pix_reg;
        end
    end

    // ---------------- stage 4: bank read/write, weight products ----------------
    // Rows (and columns) differ in parity or are both zero, so each bank sees one address.
    logic [HRW-1:0] rd_row [2];
    logic [HCW-1:0] rd_col [2];
    logic [RW-1:0]  ev_r, od_r, wsh_r;
    logic [CW-1:0]  ev_c, od_c, wsh_c;
    logic [23:0]    rd_data [4];
    logic           wr_en;

    always_comb begin
        ev_r  = s3_r0_reg[0] ? s3_r1_reg : s3_r0_reg;
        od_r  = s3_r0_reg[0] ? s3_r0_reg : s3_r1_reg;
        ev_c  = s3_c0_reg[0] ? s3_c1_reg : s3_c0_reg;
        od_c  = s3_c0_reg[0] ? s3_c0_reg : s3_c1_reg;
        ev_r  = ev_r >> 1;
        od_r  = od_r >> 1;
        ev_c  = ev_c >> 1;
        od_c  = od_c >> 1;
        rd_row[0] = ev_r[HRW-1:0];
        rd_row[1] = od_r[HRW-1:0];
        rd_col[0] = ev_c[HCW-1:0];
        rd_col[1] = od_c[HCW-1:0];
        wsh_r = s3_lrow_reg >> 1;
        wsh_c = s3_lcol_reg >> 1;
        wr_en = adv && s3_v_reg && (s3_op_reg == bir_pkg::OP_LOAD) && s3_ldok_reg;
    end

    bir_frame_store #(
        .HRW (HRW),
        .HCW (HCW)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (adv),
        .rd_row  (rd_row),
        .rd_col  (rd_col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_bank ({s3_lrow_reg[0], s3_lcol_reg[0]}),
        .wr_row  (wsh_r[HRW-1:0]),
        .wr_col  (wsh_c[HCW-1:0]),
        .wr_data (s3_pix_reg)
    );

    logic          s4_v_reg, s4_op_reg, s4_rerr_reg;
    logic [1:0]    s4_b00_reg, s4_b10_reg, s4_b01_reg, s4_b11_reg;
    logic [AW-1:0] s4_a00_reg, s4_a10_reg, s4_a01_reg, s4_a11_reg;
    logic [WB:0]   nwr, nwc;

    assign nwr = W_FULL - (WB + 1)'(s3_wr_reg);
    assign nwc = W_FULL - (WB + 1)'(s3_wc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) s4_v_reg <= 1'b0;
        else if (adv) s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_op_reg   <= s3_op_reg;
            s4_rerr_reg <= s3_rerr_reg;
            s4_b00_reg  <= {s3_r0_reg[0], s3_c0_reg[0]};
            s4_b10_reg  <= {s3_r1_reg[0], s3_c0_reg[0]};
            s4_b01_reg  <= {s3_r0_reg[0], s3_c1_reg[0]};
            s4_b11_reg  <= {s3_r1_reg[0], s3_c1_reg[0]};
            s4_a00_reg  <= AW'(nwr) * AW'(nwc);
            s4_a10_reg  <= AW'({1'b0, s3_wr_reg}) * AW'(nwc);
            s4_a01_reg  <= AW'(nwr) * AW'({1'b0, s3_wc_reg});
            s4_a11_reg  <= AW'({1'b0, s3_wr_reg}) * AW'({1'b0, s3_wc_reg});
        end
    end

    // ---------------- stage 5: channel products ----------------
    logic [23:0]   p00, p10, p01, p11;
    logic          s5_v_reg, s5_op_reg, s5_rerr_reg;
    logic [PW-1:0] s5_m_reg [3][4];

    assign p00 = rd_data[s4_b00_reg];
    assign p10 = rd_data[s4_b10_reg];
    assign p01 = rd_data[s4_b01_reg];
    assign p11 = rd_data[s4_b11_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) s5_v_reg <= 1'b0;
        else if (adv) s5_v_reg <= s4_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_op_reg   <= s4_op_reg;
            s5_rerr_reg <= s4_rerr_reg;
            for (int k = 0; k < 3; k++) begin
                s5_m_reg[k][0] <= PW'(p00[8*k +: 8]) * PW'(s4_a00_reg);
                s5_m_reg[k][1] <= PW'(p10[8*k +: 8]) * PW'(s4_a10_reg);
                s5_m_reg[k][2] <= PW'(p01[8*k +: 8]) * PW'(s4_a01_reg);
                s5_m_reg[k][3] <= PW'(p11[8*k +: 8]) * PW'(s4_a11_reg);
            end
        end
    end

    // ---------------- stage 6: blend sum, output register ----------------
    logic [SW-1:0] sum [3];
    logic [23:0]   blend;
    logic [23:0]   m_tdata_reg;
    logic          m_tuser_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = SW'(s5_m_reg[k][0]) + SW'(s5_m_reg[k][1]) +
                     SW'(s5_m_reg[k][2]) + SW'(s5_m_reg[k][3]);
            blend[8*k +: 8] = sum[k][2*WB +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else if (adv) m_tvalid_reg <= s5_v_reg && (s5_op_reg == bir_pkg::OP_INTERP);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tuser_reg <= s5_rerr_reg;
            m_tdata_reg <= s5_rerr_reg ? 24'd0 : blend;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- checks ----------------
    logic [4:0] vld_vec;
    assign vld_vec = {s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg};

    `BIR_ASSERT_IMP(a_rerr_zero, m_tvalid && m_tuser, m_tdata == 24'd0, "range error with data")
    `BIR_ASSERT_NXT(a_stall_hold, !adv, $stable(vld_vec) && m_tvalid, "stage moved in stall")
    `BIR_ASSERT_IMP(a_edge_one, s3_v_reg && (s3_r0_reg == s3_r1_reg), rows_eff == SRW'(1),
                    "equal rows on a tall image")
    `BIR_ASSERT_IMP(a_out_src, $rose(m_tvalid_reg),
                    $past(s5_v_reg) && ($past(s5_op_reg) == bir_pkg::OP_INTERP),
                    "result without request")

endmodule

// ===== hdl/bir_frame_store.sv =====
`timescale 1ns / 1ps
// Four banks split by row and column parity; one read port per bank, registered.
module bir_frame_store #(
    parameter int HRW = 8,
    parameter int HCW = 8
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [HRW-1:0]                rd_row [2],
    input  logic [HCW-1:0]                rd_col [2],
    output logic [bir_pkg::PIX_W-1:0]     rd_data [4],
    input  logic                          wr_en,
    input  logic [1:0]                    wr_bank,
    input  logic [HRW-1:0]                wr_row,
    input  logic [HCW-1:0]                wr_col,
    input  logic [bir_pkg::PIX_W-1:0]     wr_data
);

    localparam int DEPTH = 1 << (HRW + HCW);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [bir_pkg::PIX_W-1:0] mem [DEPTH];

        always_ff @(posedge aclk) begin
            if (wr_en && (wr_bank == 2'(b))) begin
                mem[{wr_row, wr_col}] <= wr_data;
            end
        end

        always_ff @(posedge aclk) begin
            if (rd_en) begin
                rd_data[b] <= mem[{rd_row[b / 2], rd_col[b % 2]}];
            end
        end
    end

endmodule
